// File: hw/rtl/obf_pkg.sv
`default_nettype none

package obf_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 29;

  // Coefficient registers are always 32-bit signed
  localparam int COEF_WIDTH    = 32;
  localparam int CFG_IDX_WIDTH = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_A2 = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the accepted input item
    logic mul;         // register the five products
    logic sub2;        // operands of the second sub-step
    logic add;         // first adder level
    logic sum_first;   // final sum, keep as first sub-step value
    logic sum_commit;  // final sum, write output and update history
  } obf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;    // output register can take a new result this cycle
  } obf_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/obf_ctrl.sv
`default_nettype none

module obf_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  output obf_pkg::obf_cmd_t   cmd,
  input  obf_pkg::obf_stat_t  stat
);
  import obf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL1 = 7'b0000010,
    S_ADD1 = 7'b0000100,
    S_SUM1 = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_ADD2 = 7'b0100000,
    S_SUM2 = 7'b1000000
  } obf_state_t;

  obf_state_t state;
  obf_state_t state_next;

  assign s_tready = (state == S_IDLE);

  // Sequence: two sub-steps of multiply, add, sum/round/saturate
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD1;
      end
      S_ADD1: begin
        cmd.add    = 1'b1;
        state_next = S_SUM1;
      end
      S_SUM1: begin
        cmd.sum_first = 1'b1;
        state_next    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul    = 1'b1;
        cmd.sub2   = 1'b1;
        state_next = S_ADD2;
      end
      S_ADD2: begin
        cmd.add    = 1'b1;
        state_next = S_SUM2;
      end
      S_SUM2: begin
        // hold here while the previous result is still unread
        if (stat.out_free) begin
          cmd.sum_commit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/obf_datapath.sv
`default_nettype none

module obf_datapath #(
  parameter int SAMPLE_WIDTH   = obf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = obf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // input item
  input  wire        [SAMPLE_WIDTH-1:0]       in_sample,
  input  wire                                 in_last,
  // result item
  output logic       [SAMPLE_WIDTH-1:0]       out_sample,
  output logic                                out_last,
  output logic                                out_valid,
  input  wire                                 out_ready,
  // coefficient writes
  input  wire                                 cfg_we,
  input  wire        [obf_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire        [obf_pkg::COEF_WIDTH-1:0]    cfg_data,
  // control
  input  obf_pkg::obf_cmd_t                   cmd,
  output obf_pkg::obf_stat_t                  stat
);
  import obf_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = COEF_WIDTH + SAMPLE_WIDTH;  // product width
  localparam int AW = PW + 3;                     // sum of five products plus rounding
  localparam logic [COEF_WIDTH-1:0] UnityCoef =
    COEF_WIDTH'(1) << COEF_FRAC_BITS;
  localparam logic signed [AW-1:0] RoundHalf =
    AW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [SW-1:0] SatMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SatMin = {1'b1, {(SW-1){1'b0}}};

  // Coefficients
  logic signed [COEF_WIDTH-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  // Sample history and working values
  logic signed [SW-1:0] x_cur;
  logic                 last_in;
  logic signed [SW-1:0] prev_input;
  logic signed [SW-1:0] prev_output;
  logic signed [SW-1:0] prev_prev_output;
  logic signed [SW-1:0] first_y;

  // Operands for the five multipliers
  logic signed [SW-1:0] op_x1, op_x2, op_y1, op_y2;

  // Pipeline registers
  logic signed [PW-1:0] p0, p1, p2, p3, p4;
  logic signed [AW-1:0] s0, s1, s2;

  // Final sum, rounding shift and saturation
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] acc_sh;
  logic        [SW-1:0] sat_y;
  logic                 in_range;

  // Coefficient registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= UnityCoef;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:  coef_b0 <= cfg_data;
        REG_B1:  coef_b1 <= cfg_data;
        REG_B2:  coef_b2 <= cfg_data;
        REG_A1:  coef_a1 <= cfg_data;
        REG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand select: first sub-step holds the previous input on both taps
  always_comb begin
    if (cmd.sub2) begin
      op_x1 = x_cur;
      op_x2 = prev_input;
      op_y1 = first_y;
      op_y2 = prev_output;
    end else begin
      op_x1 = prev_input;
      op_x2 = prev_input;
      op_y1 = prev_output;
      op_y2 = prev_prev_output;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_cur   <= in_sample;
      last_in <= in_last;
    end
  end

  // Five parallel multipliers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p0 <= PW'(coef_b0 * x_cur);
      p1 <= PW'(coef_b1 * op_x1);
      p2 <= PW'(coef_b2 * op_x2);
      p3 <= PW'(coef_a1 * op_y1);
      p4 <= PW'(coef_a2 * op_y2);
    end
  end

  // First adder level; feedback terms subtract, rounding constant folded in
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      s0 <= AW'(p0) + AW'(p1);
      s1 <= AW'(p2) - AW'(p3);
      s2 <= RoundHalf - AW'(p4);
    end
  end

  // Final sum, shift out the fraction and clamp to the sample range
  always_comb begin
    acc      = s0 + s1 + s2;
    acc_sh   = acc >>> COEF_FRAC_BITS;
    in_range = (&acc_sh[AW-1:SW-1]) || !(|acc_sh[AW-1:SW-1]);
    if (in_range) begin
      sat_y = acc_sh[SW-1:0];
    end else if (acc_sh[AW-1]) begin
      sat_y = SatMin;
    end else begin
      sat_y = SatMax;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_first) begin
      first_y <= sat_y;
    end
  end

  // History update at the end of the second sub-step
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_input       <= '0;
      prev_output      <= '0;
      prev_prev_output <= '0;
    end else if (cmd.sum_commit) begin
      prev_input       <= x_cur;
      prev_output      <= sat_y;
      prev_prev_output <= first_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.sum_commit) begin
      out_sample <= sat_y;
      out_last   <= last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sum_commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: hw/rtl/oversampled_biquad_filter.sv
`default_nettype none

// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tdata: sample_in; tlast: block_end
// m_*      out        m_tvalid/m_tready  tdata: sample_out; tlast: block_end_out
// cfg_*    in         cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// An item passes one accept step, then multiply, add and
// sum/round/saturate for each of the two sub-steps on one set of five
// multipliers. The result is written to the output register by the second sum step.
// Reset (rst, synchronous) restores the coefficients and clears history.
// A result waits in the output register; the next item is accepted
// meanwhile and stalls at its last step only if that result is still unread.
module oversampled_biquad_filter #(
  parameter int SAMPLE_WIDTH   = obf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = obf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst,
  // input items
  input  wire                                      s_tvalid,
  output logic                                     s_tready,
  input  wire  [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // sample_in, zero pad
  input  wire                                      s_tlast,
  // result items
  output logic                                     m_tvalid,
  input  wire                                      m_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // sample_out, zero pad
  output logic                                     m_tlast,
  // coefficient writes
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire  [obf_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
  input  wire  [obf_pkg::COEF_WIDTH-1:0]           cfg_data
);
  import obf_pkg::*;

  localparam int DataWidth = ((SAMPLE_WIDTH + 7) / 8) * 8;

  obf_cmd_t              cmd;
  obf_stat_t             stat;
  logic [SAMPLE_WIDTH-1:0] out_sample;

  // Writes must come only while idle; the block itself does not enforce this, and the port is always open
  assign cfg_ready = 1'b1;

  obf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  obf_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .in_sample  (s_tdata[SAMPLE_WIDTH-1:0]),
    .in_last    (s_tlast),
    .out_sample (out_sample),
    .out_last   (m_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat)
  );

  assign m_tdata = DataWidth'(out_sample);

endmodule

`default_nettype wire

// File: sim/oversampled_biquad_filter_tb.sv
`timescale 1ns / 100ps

module oversampled_biquad_filter_tb;
  import obf_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam int TDW = ((SW + 7) / 8) * 8;
  localparam longint SMAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int CHUNK_ITEMS = 60;

  typedef logic signed [SW-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef struct packed {
    logic    last;
    sample_t smp;
  } filtered_t;

  localparam coef_t COEF_MAX = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
  localparam coef_t COEF_ONE = coef_t'(longint'(1) <<< FRAC);
  localparam coef_t COEF_HALF = coef_t'(longint'(1) <<< (FRAC - 1));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDW-1:0] s_tdata = '0;  // sample_in, zero pad
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDW-1:0] m_tdata;       // sample_out, zero pad
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [COEF_WIDTH-1:0] cfg_data = '0;

  // predictor state: coefficients and filter history
  coef_t b0_gain = COEF_ONE;
  coef_t b1_gain = '0;
  coef_t b2_gain = '0;
  coef_t a1_fb = '0;
  coef_t a2_fb = '0;
  sample_t x_hist = '0;
  sample_t y_hist1 = '0;
  sample_t y_hist2 = '0;

  filtered_t filtered_q[$];

  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_len = 0;
  int errors = 0;
  int samples_sent = 0;
  int directed_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int watchdog_cycles;

  oversampled_biquad_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one direct-form-I sub-step: exact sum, round half up, saturate
  function automatic sample_t biquad_substep(sample_t x0, sample_t x1, sample_t x2,
                                             sample_t y1, sample_t y2);
    longint acc;
    acc = longint'(b0_gain) * longint'(x0) + longint'(b1_gain) * longint'(x1)
        + longint'(b2_gain) * longint'(x2) - longint'(a1_fb) * longint'(y1)
        - longint'(a2_fb) * longint'(y2);
    acc = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    if (acc > SMAX) acc = SMAX;
    else if (acc < SMIN) acc = SMIN;
    return sample_t'(acc);
  endfunction

  // two sub-steps per sample with the input held; only the second is output
  function automatic void predict_filter(sample_t x, logic last);
    sample_t mid;
    sample_t outv;
    filtered_t item;
    mid = biquad_substep(x, x_hist, x_hist, y_hist1, y_hist2);
    outv = biquad_substep(x, x, x_hist, mid, y_hist1);
    x_hist = x;
    y_hist2 = mid;
    y_hist1 = outv;
    item.smp = outv;
    item.last = last;
    filtered_q.push_back(item);
  endfunction

  function automatic void apply_coef(logic [CFG_IDX_WIDTH-1:0] idx, coef_t val);
    case (idx)
      REG_B0: b0_gain = val;
      REG_B1: b1_gain = val;
      REG_B2: b2_gain = val;
      REG_A1: a1_fb = val;
      REG_A2: a2_fb = val;
      default: ;  // spare index, write dropped
    endcase
  endfunction

  function automatic coef_t rand_coef(int unsigned span);
    return coef_t'(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  function automatic coef_t extreme_coef();
    case ($urandom_range(0, 3))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return COEF_ONE;
      default: return '0;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return sample_t'(SMAX);
          1: return sample_t'(SMIN);
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return sample_t'(int'($urandom_range(0, 2048)) - 1024);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // send one item, with a random idle gap in front
  task automatic send_sample(input sample_t smp, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= TDW'($unsigned(smp));
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    predict_filter(smp, last);
    samples_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic flush_filter();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (filtered_q.size() != 0);
  endtask

  task automatic write_coef(input logic [CFG_IDX_WIDTH-1:0] idx, input coef_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_coef(idx, val);
    cfg_writes++;
  endtask

  task automatic set_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                           input coef_t a1, input coef_t a2);
    write_coef(REG_B0, b0);
    write_coef(REG_B1, b1);
    write_coef(REG_B2, b2);
    write_coef(REG_A1, a1);
    write_coef(REG_A2, a2);
    cfg_valid <= 1'b0;
  endtask

  // full-range, extreme or moderate (roughly audio-like) coefficient sets
  task automatic choose_coefs();
    case ($urandom_range(0, 3))
      0: set_coefs(coef_t'($urandom()), coef_t'($urandom()), coef_t'($urandom()),
                   coef_t'($urandom()), coef_t'($urandom()));
      1: set_coefs(extreme_coef(), extreme_coef(), extreme_coef(),
                   extreme_coef(), extreme_coef());
      default: set_coefs(rand_coef(1 << FRAC), rand_coef(1 << FRAC), rand_coef(1 << FRAC),
                         rand_coef((2 << FRAC) - 1),
                         rand_coef((1 << FRAC) - (1 << (FRAC - 3))));
    endcase
  endtask

  // reset coefficients pass the input straight through
  task automatic test_reset_passthrough();
    send_sample('0, 1'b0);
    send_sample(sample_t'(SMAX), 1'b1);
    send_sample(sample_t'(SMIN), 1'b0);
    send_sample('1, 1'b1);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(24'h555555), 1'b1);
    flush_filter();
  endtask

  // writes to indexes past the last register must change nothing
  task automatic test_spare_index();
    for (int i = int'(REG_A2) + 1; i < (1 << CFG_IDX_WIDTH); i++)
      write_coef(CFG_IDX_WIDTH'(i), coef_t'($urandom()));
    cfg_valid <= 1'b0;
    send_sample(sample_t'(24'h2aaaaa), 1'b0);
    send_sample(sample_t'(-12345), 1'b1);
    flush_filter();
  endtask

  // overflow toward both ends of the sample range
  task automatic test_saturation();
    set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, '0, '0);
    send_sample(sample_t'(SMAX), 1'b0);
    send_sample(sample_t'(SMIN), 1'b1);
    flush_filter();
    set_coefs(COEF_MIN, '0, '0, COEF_MIN, COEF_MAX);
    send_sample(sample_t'(SMAX), 1'b0);
    send_sample(sample_t'(-3), 1'b0);
    flush_filter();
  endtask

  // gain of one half: odd inputs land exactly on a half
  task automatic test_rounding_ties();
    set_coefs(COEF_HALF, '0, '0, '0, '0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(3), 1'b1);
    send_sample(sample_t'(-3), 1'b0);
    send_sample(sample_t'(SMAX), 1'b0);
    send_sample(sample_t'(SMIN), 1'b1);
    flush_filter();
  endtask

  // long receiver hold while the sender keeps pushing
  task automatic test_backpressure();
    choose_coefs();
    send_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_len = 300;
    for (int i = 0; i < 30; i++) send_sample(rand_sample(), $urandom_range(0, 7) == 0);
    flush_filter();
  endtask

  task automatic test_random_phase(input int send_pct, input int stall_pct, input int n_items);
    send_idle_pct = send_pct;
    rcv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        flush_filter();
        choose_coefs();
      end
      send_sample(rand_sample(), $urandom_range(0, 7) == 0);
    end
    flush_filter();
  endtask

  // receiver side: random stalls, the long hold, and the result check
  always @(posedge clk) begin : result_monitor
    filtered_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (filtered_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d last %0b",
                 $time, $signed(m_tdata[SW-1:0]), m_tlast);
      end else begin
        want = filtered_q.pop_front();
        results_checked++;
        if (m_tdata[SW-1:0] !== want.smp) begin
          errors++;
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $time, want.smp, $signed(m_tdata[SW-1:0]));
        end
        if (m_tlast !== want.last) begin
          errors++;
          $display("%0t: block_end_out mismatch, expected %0b, actual %0b",
                   $time, want.last, m_tlast);
        end
      end
    end
    if (hold_len > 0) begin
      hold_len--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  initial begin : watchdog
    for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
      @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_passthrough();
    test_spare_index();
    test_saturation();
    test_rounding_ties();
    directed_sent = samples_sent;
    test_backpressure();
    test_random_phase(0, 0, 460);
    test_random_phase(83, 0, 460);
    test_random_phase(0, 83, 460);
    test_random_phase(17, 17, 460);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d samples (%0d directed), checked %0d results, %0d coefficient writes",
             samples_sent, directed_sent, results_checked, cfg_writes);
    $display("Covered passthrough, saturation, rounding ties, spare indexes, back-pressure");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/obf_pkg.sv
hw/rtl/obf_ctrl.sv
hw/rtl/obf_datapath.sv
hw/rtl/oversampled_biquad_filter.sv
sim/oversampled_biquad_filter_tb.sv
